/* sv/rrb_pkg.sv */
// Shared types, constants and helpers for the record ring buffer controller.
// Used by every module of the block but rrb_ram; depends on nothing else.
package rrb_pkg;

  // Buffer geometry
  localparam int CAPACITY_BYTES = 4096;
  localparam int POSITION_BITS  = 32;
  localparam int HDR_BYTES      = 8;
  localparam int CAP_W          = $clog2(CAPACITY_BYTES);
  localparam int SLOT_W         = CAP_W - 3;
  localparam int SLOT_COUNT     = CAPACITY_BYTES / HDR_BYTES;
  localparam int MAX_PAYLOAD    = CAPACITY_BYTES - HDR_BYTES;

  // Field widths
  localparam int SIZE_W = 32;
  localparam int OFF_W  = 12;
  localparam int HDR_W  = CAP_W + 2;

  // Queue depths between the parts
  localparam int REQ_Q_DEPTH = 2;
  localparam int REQ_Q_AW    = $clog2(REQ_Q_DEPTH);
  localparam int OUT_Q_DEPTH = 2;
  localparam int OUT_Q_AW    = $clog2(OUT_Q_DEPTH);

  // Request codes
  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_COMMIT  = 2'd1;
  localparam logic [1:0] REQ_FETCH   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FLAGS    = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;
  localparam logic [2:0] ST_SKIPPED  = 3'd5;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] request_size;
    logic [OFF_W-1:0]  sample_offset;
    logic              discard;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] payload_offset;
    logic [OFF_W-1:0] payload_length;
    logic             data_ready;
  } out_item_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [1:0]        kind;
    logic              size_err;
    logic              too_big;
    logic [CAP_W-1:0]  len;
    logic [CAP_W:0]    need;
    logic [SLOT_W-1:0] slot;
    logic              discard;
  } req_t;

  // Header word kept per 8-byte slot
  typedef struct packed {
    logic             busy;
    logic             discard;
    logic [CAP_W-1:0] len;
  } hdr_t;

  // Round payload length plus header up to a multiple of 8
  function automatic logic [CAP_W:0] round_len(input logic [CAP_W-1:0] len);
    logic [CAP_W:0] sum;
    sum = {1'b0, len} + (CAP_W+1)'(HDR_BYTES + 7);
    return {sum[CAP_W:3], 3'b000};
  endfunction

endpackage

/* sv/rrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module rrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rrb_front.sv */
// Front part: accepts request transactions, classifies them, and holds them
// in a short queue for the back part. Depends on rrb_pkg.
module rrb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  rrb_pkg::in_item_t item,
  output logic             req_valid,
  output rrb_pkg::req_t    req,
  input  logic             req_pop
);
  import rrb_pkg::*;

  req_t                q [REQ_Q_DEPTH];
  logic [REQ_Q_AW-1:0] wr_ptr;
  logic [REQ_Q_AW-1:0] rd_ptr;
  logic [REQ_Q_AW:0]   count;
  logic                accept;
  logic                take;
  req_t                cls;
  logic [CAP_W-1:0]    len;
  logic [CAP_W-1:0]    hoff;

  // Classify the incoming request
  always_comb begin
    len          = CAP_W'(item.request_size);
    hoff         = CAP_W'(item.sample_offset) + CAP_W'(MAX_PAYLOAD);
    cls.kind     = item.req_type;
    cls.size_err = item.request_size[SIZE_W-1] | item.request_size[SIZE_W-2];
    cls.too_big  = item.request_size > SIZE_W'(MAX_PAYLOAD);
    cls.len      = len;
    cls.need     = round_len(len);
    cls.slot     = hoff[CAP_W-1:3];
    cls.discard  = item.discard;
  end

  assign full      = (count == (REQ_Q_AW+1)'(REQ_Q_DEPTH));
  assign accept    = push & ~full;
  assign req_valid = (count != '0);
  assign take      = req_pop & req_valid;
  assign req       = q[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cls;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + REQ_Q_AW'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + REQ_Q_AW'(1);
      end
      case ({accept, take})
        2'b10:   count <= count + (REQ_Q_AW+1)'(1);
        2'b01:   count <= count - (REQ_Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/rrb_back.sv */
// Back part: carries out classified requests against the header store and
// the producer/consumer positions. Depends on rrb_pkg and rrb_ram.
module rrb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  rrb_pkg::req_t     req,
  output logic              req_pop,
  input  logic              out_full,
  output logic              out_push,
  output rrb_pkg::out_item_t out_item
);
  import rrb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HEAD} state_t;

  state_t                   state, state_next;
  logic [POSITION_BITS-1:0] wp, wp_next;
  logic [POSITION_BITS-1:0] rp, rp_next;
  logic                     head_busy, head_busy_next;
  req_t                     cur, cur_next;
  out_item_t                res, res_next;

  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_waddr;
  hdr_t                     ram_wdata;
  logic                     ram_re;
  logic [SLOT_W-1:0]        ram_raddr;
  logic [HDR_W-1:0]         ram_rdata;
  hdr_t                     rd_hdr;

  logic [POSITION_BITS-1:0] used;
  logic [POSITION_BITS-1:0] avail;
  logic                     has_data;
  logic                     hold;

  rrb_ram #(
    .WIDTH (HDR_W),
    .DEPTH (SLOT_COUNT)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_hdr   = ram_rdata;
  assign used     = wp - rp;
  assign avail    = POSITION_BITS'(CAPACITY_BYTES) - used;
  assign has_data = (used != '0);

  // Sequence one request: look up header, then update header and positions
  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    head_busy_next = head_busy;
    cur_next       = cur;
    res_next       = res;
    req_pop        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wp[CAP_W-1:3];
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = rp[CAP_W-1:3];
    out_push       = 1'b0;
    out_item       = res;
    hold           = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid && !out_full) begin
          req_pop    = 1'b1;
          cur_next   = req;
          ram_re     = 1'b1;
          ram_raddr  = (req.kind == REQ_COMMIT) ? req.slot : rp[CAP_W-1:3];
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        out_item            = '0;
        out_item.data_ready = has_data & ~head_busy;
        case (cur.kind)
          REQ_RESERVE: begin
            if (cur.size_err) begin
              out_item.status = ST_FLAGS;
            end else if (cur.too_big || used > POSITION_BITS'(CAPACITY_BYTES) ||
                         avail < POSITION_BITS'(cur.need)) begin
              out_item.status = ST_NO_SPACE;
            end else begin
              ram_we                  = 1'b1;
              ram_wdata.busy          = 1'b1;
              ram_wdata.discard       = 1'b0;
              ram_wdata.len           = cur.len;
              out_item.payload_offset = OFF_W'(wp[CAP_W-1:0] + CAP_W'(HDR_BYTES));
              wp_next                 = wp + POSITION_BITS'(cur.need);
              // A record written into an empty buffer becomes the busy head
              if (!has_data) begin
                head_busy_next      = 1'b1;
                out_item.data_ready = 1'b0;
              end
            end
          end
          REQ_COMMIT: begin
            ram_we            = 1'b1;
            ram_waddr         = cur.slot;
            ram_wdata.busy    = 1'b0;
            ram_wdata.discard = rd_hdr.discard | cur.discard;
            ram_wdata.len     = rd_hdr.len;
            if (has_data && cur.slot == rp[CAP_W-1:3]) begin
              head_busy_next      = 1'b0;
              out_item.data_ready = 1'b1;
            end
          end
          REQ_FETCH: begin
            if (!has_data) begin
              out_item.status = ST_EMPTY;
            end else if (rd_hdr.busy) begin
              out_item.status     = ST_BUSY;
              out_item.data_ready = 1'b0;
            end else begin
              rp_next = rp + POSITION_BITS'(round_len(rd_hdr.len));
              if (rd_hdr.discard) begin
                out_item.status = ST_SKIPPED;
              end else begin
                out_item.payload_offset = OFF_W'(rp[CAP_W-1:0] + CAP_W'(HDR_BYTES));
                out_item.payload_length = OFF_W'(rd_hdr.len);
              end
              // Look up the new head unless the buffer drained
              if (wp == rp_next) begin
                out_item.data_ready = 1'b0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rp_next[CAP_W-1:3];
                hold      = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (hold) begin
          res_next   = out_item;
          state_next = S_HEAD;
        end else begin
          out_push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HEAD: begin
        out_item            = res;
        out_item.data_ready = ~rd_hdr.busy;
        head_busy_next      = rd_hdr.busy;
        out_push            = 1'b1;
        state_next          = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, positions and the pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      rp        <= '0;
      head_busy <= 1'b0;
    end else begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      head_busy <= head_busy_next;
    end
    cur <= cur_next;
    res <= res_next;
  end

endmodule

/* sv/rrb_out_queue.sv */
// Result queue: parts the back part from the result receiver.
// Depends on rrb_pkg.
module rrb_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rrb_pkg::out_item_t item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output rrb_pkg::out_item_t result
);
  import rrb_pkg::*;

  out_item_t           q [OUT_Q_DEPTH];
  logic [OUT_Q_AW-1:0] wr_ptr;
  logic [OUT_Q_AW-1:0] rd_ptr;
  logic [OUT_Q_AW:0]   count;
  logic                put;
  logic                take;

  assign full   = (count == (OUT_Q_AW+1)'(OUT_Q_DEPTH));
  assign empty  = (count == '0);
  assign put    = push & ~full;
  assign take   = pop & ~empty;
  assign result = q[rd_ptr];

  // Store entry
  always_ff @(posedge clk) begin
    if (put) begin
      q[wr_ptr] <= item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (put) begin
        wr_ptr <= wr_ptr + OUT_Q_AW'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + OUT_Q_AW'(1);
      end
      case ({put, take})
        2'b10:   count <= count + (OUT_Q_AW+1)'(1);
        2'b01:   count <= count - (OUT_Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/record_ring_buffer_reserve_commit.sv */
// Record ring buffer controller: top level.
// Depends on rrb_pkg, rrb_front, rrb_back and rrb_out_queue.
//
// Usage:
//   Requests enter through a queue-like port: a transaction is taken at a
//   rising edge where push is high and full is low. req_type selects
//   reserve, commit/discard or fetch; request_size, sample_offset and
//   discard carry the operands.
//   Results leave through a queue-like port: while empty is low the oldest
//   result sits on result, and it is taken at an edge where pop is high.
//   Every request gives exactly one result, in request order.
// Sequencing:
//   The back part carries out one request at a time: it takes a request in
//   S_IDLE, acts on it in S_EXEC and takes the next one only back in S_IDLE.
//   The header store has one read port with registered data, so a header
//   lookup is issued in S_IDLE and its data is used in S_EXEC; a fetch that
//   leaves more records behind reads the new head header in S_HEAD.
// Reset:
//   rst (synchronous) empties both queues and sets both positions to zero.
//   Header words hold no reset value; a commit that names a slot never written acts on an undefined header.
// Stalls:
//   When pop stays low, up to two results wait; then processing stops and
//   up to two more requests queue before full rises.
module record_ring_buffer_reserve_commit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rrb_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output rrb_pkg::out_item_t result
);
  import rrb_pkg::*;

  logic      req_valid;
  req_t      req;
  logic      req_pop;
  logic      out_full;
  logic      out_push;
  out_item_t out_item;

  rrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  rrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  rrb_out_queue u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (out_push),
    .item   (out_item),
    .full   (out_full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

/* sv/rrb_checker.sv */
// Port-level checks for the record ring buffer controller, bound to the top.
// Depends on rrb_pkg and record_ring_buffer_reserve_commit.
module rrb_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input rrb_pkg::out_item_t result
);
  import rrb_pkg::*;

  // Reset leaves both queues empty
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A waiting result holds until taken
  assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result changed");

  // Status stays within its defined codes
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.status <= ST_SKIPPED)
    else $error("undefined status code");

  // Failed and skipped results carry no offset or length
  assert property (@(posedge clk) disable iff (rst)
    !empty && result.status != ST_OK |->
      result.payload_offset == '0 && result.payload_length == '0)
    else $error("failed result carries offset or length");

  // A result never appears straight out of reset
  assert property (@(posedge clk) disable iff (rst)
    $past(empty) && !empty |-> !$past(rst))
    else $error("result appeared straight out of reset");

endmodule

bind record_ring_buffer_reserve_commit rrb_checker u_rrb_checker (.*);

/* bench/tb_record_ring_buffer_reserve_commit.sv */
// Self-checking bench for record_ring_buffer_reserve_commit: directed and random
// reserve, commit and fetch traffic checked against a shadow of the ring state.
// Depends on rrb_pkg and the block's top module.
module tb_record_ring_buffer_reserve_commit;
  import rrb_pkg::*;

  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [31:0] SIZE_FLAGS = 32'hC000_0000;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 10;

  logic      clk;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  req_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t rsp;

  // Shadow of the ring: positions, header words and which slots hold a header
  logic [POSITION_BITS-1:0] shadow_wpos = '0;
  logic [POSITION_BITS-1:0] shadow_rpos = '0;
  hdr_t                     shadow_hdr [SLOT_COUNT];
  bit                       slot_written [SLOT_COUNT];
  int                       written_slots [$];

  out_item_t        awaited_results [$];
  out_item_t        last_expect;
  logic [OFF_W-1:0] open_offsets [$];
  int               send_idle_pct = 16;
  int               take_idle_pct = 61;
  int               fail_count = 0;
  int               cycle_count = 0;

  record_ring_buffer_reserve_commit u_top (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (req_item),
    .empty  (empty),
    .pop    (pop),
    .result (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_record_ring_buffer_reserve_commit: errors");
      $finish;
    end
  end

  // Randomly stall the result side
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= take_idle_pct);
  end

  // Compare each popped transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: %p", rsp);
        fail_count = fail_count + 1;
      end else begin
        want = awaited_results.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fail_count = fail_count + 1;
        end
        if (rsp.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d", want.payload_offset,
                 rsp.payload_offset);
          fail_count = fail_count + 1;
        end
        if (rsp.payload_length !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 rsp.payload_length);
          fail_count = fail_count + 1;
        end
        if (rsp.data_ready !== want.data_ready) begin
          $error("data_ready: expected %0d, got %0d", want.data_ready, rsp.data_ready);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Bytes needed by a record: payload plus header, rounded up to 8
  function automatic logic [32:0] record_bytes(input logic [31:0] len);
    logic [32:0] sum;
    sum = {1'b0, len} + 33'd15;
    return {sum[32:3], 3'b000};
  endfunction

  function automatic logic head_ready();
    if (shadow_wpos == shadow_rpos) return 1'b0;
    return !shadow_hdr[shadow_rpos[CAP_W-1:3]].busy;
  endfunction

  // Apply one request to the shadow ring and return the result it yields
  function automatic out_item_t ring_step(input in_item_t req);
    out_item_t                res;
    logic [POSITION_BITS-1:0] used;
    logic [32:0]              avail;
    logic [32:0]              need;
    logic [OFF_W-1:0]         hoff;
    hdr_t                     hw;
    logic [SLOT_W-1:0]        slot;
    res = '0;
    used = shadow_wpos - shadow_rpos;
    case (req.req_type)
      REQ_RESERVE: begin
        if ((req.request_size & SIZE_FLAGS) != 0) begin
          res.status = ST_FLAGS;
        end else begin
          avail = (used > CAPACITY_BYTES) ? 33'd0 : 33'(CAPACITY_BYTES) - 33'(used);
          need = record_bytes(req.request_size);
          if (need > CAPACITY_BYTES || avail < need) begin
            res.status = ST_NO_SPACE;
          end else begin
            slot = shadow_wpos[CAP_W-1:3];
            shadow_hdr[slot] = '{busy: 1'b1, discard: 1'b0,
                                 len: req.request_size[CAP_W-1:0]};
            if (!slot_written[slot]) begin
              slot_written[slot] = 1'b1;
              written_slots.push_back(int'(slot));
            end
            res.status = ST_OK;
            res.payload_offset = shadow_wpos[OFF_W-1:0] + OFF_W'(HDR_BYTES);
            shadow_wpos = shadow_wpos + need[POSITION_BITS-1:0];
          end
        end
      end
      REQ_COMMIT: begin
        hoff = req.sample_offset - OFF_W'(HDR_BYTES);
        slot = hoff[CAP_W-1:3];
        hw = shadow_hdr[slot];
        hw.busy = 1'b0;
        if (req.discard) hw.discard = 1'b1;
        shadow_hdr[slot] = hw;
        res.status = ST_OK;
      end
      REQ_FETCH: begin
        if (used == 0) begin
          res.status = ST_EMPTY;
        end else begin
          hw = shadow_hdr[shadow_rpos[CAP_W-1:3]];
          if (hw.busy) begin
            res.status = ST_BUSY;
          end else begin
            res.payload_offset = shadow_rpos[OFF_W-1:0] + OFF_W'(HDR_BYTES);
            shadow_rpos = shadow_rpos + POSITION_BITS'(record_bytes(32'(hw.len)));
            if (hw.discard) begin
              res.status = ST_SKIPPED;
              res.payload_offset = '0;
            end else begin
              res.status = ST_OK;
              res.payload_length = hw.len;
            end
          end
        end
      end
      default: res.status = ST_OK;
    endcase
    res.data_ready = head_ready();
    return res;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] kind, input logic [31:0] size,
                                         input logic [OFF_W-1:0] offset, input logic disc);
    in_item_t it;
    it.req_type = kind;
    it.request_size = size;
    it.sample_offset = offset;
    it.discard = disc;
    return it;
  endfunction

  // Send one transaction, with random idle cycles ahead of it
  task automatic issue_request(input in_item_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    req_item <= req;
    do @(posedge clk); while (full);
    last_expect = ring_step(req);
    awaited_results.push_back(last_expect);
    if (req.req_type == REQ_RESERVE && last_expect.status == ST_OK)
      open_offsets.push_back(last_expect.payload_offset);
  endtask

  // Hold off the sender until every expected result has been popped
  task automatic drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_size_flags();
    issue_request(make_item(REQ_FETCH, $urandom, OFF_W'($urandom), 1'($urandom)));
    issue_request(make_item(REQ_RESERVE, 32'h8000_0000, '0, 1'b0));
    issue_request(make_item(REQ_RESERVE, 32'h4000_0000, '0, 1'b0));
    issue_request(make_item(REQ_RESERVE, 32'hFFFF_FFFF, '1, 1'b1));
  endtask

  // Oversize, exact fit, full ring, busy head and a discarded whole-ring record
  task automatic test_capacity();
    logic [OFF_W-1:0] big_off;
    issue_request(make_item(REQ_RESERVE, 32'd4089, '0, 1'b0));
    issue_request(make_item(REQ_RESERVE, 32'd4088, '0, 1'b0));
    big_off = last_expect.payload_offset;
    issue_request(make_item(REQ_RESERVE, 32'd0, '0, 1'b0));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
    issue_request(make_item(REQ_COMMIT, '0, big_off, 1'b1));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
  endtask

  // Out-of-order commit, unaligned offsets, sticky discard, skip and deliver
  task automatic test_commit_fetch();
    logic [OFF_W-1:0] off_a;
    logic [OFF_W-1:0] off_b;
    issue_request(make_item(REQ_RESERVE, 32'd0, '0, 1'b0));
    off_a = last_expect.payload_offset;
    issue_request(make_item(REQ_RESERVE, 32'd5, '0, 1'b0));
    off_b = last_expect.payload_offset;
    issue_request(make_item(REQ_COMMIT, '0, off_b + OFF_W'(7), 1'b0));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
    issue_request(make_item(REQ_COMMIT, '0, off_a, 1'b1));
    issue_request(make_item(REQ_COMMIT, '0, off_a + OFF_W'(3), 1'b0));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
  endtask

  task automatic test_unknown_request();
    logic [OFF_W-1:0] off;
    issue_request(make_item(REQ_UNUSED, '1, '1, 1'b1));
    issue_request(make_item(REQ_RESERVE, 32'd12, '0, 1'b0));
    off = last_expect.payload_offset;
    issue_request(make_item(REQ_COMMIT, '0, off, 1'b0));
    issue_request(make_item(REQ_UNUSED, $urandom, OFF_W'($urandom), 1'($urandom)));
    issue_request(make_item(REQ_FETCH, '0, '0, 1'b0));
  endtask

  // Mostly well-formed reserve/commit/fetch traffic with noise mixed in
  task automatic test_random_traffic(input int n_items);
    in_item_t    req;
    int          pick;
    int          idx;
    logic [2:0]  lo;
    logic [31:0] size;
    open_offsets.delete();
    for (int n = 0; n < n_items; n++) begin
      req = make_item(2'($urandom), $urandom, OFF_W'($urandom), 1'($urandom));
      lo = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 35) begin
        req.req_type = REQ_RESERVE;
        pick = $urandom_range(99);
        if (pick < 10) begin
          size = $urandom;
          if ((size & SIZE_FLAGS) == 0) size[30 + $urandom_range(1)] = 1'b1;
        end else if (pick < 15) begin
          size = $urandom_range(32'h3FFF_FFFF, 4089);
        end else if (pick < 30) begin
          size = $urandom_range(MAX_PAYLOAD, 121);
        end else begin
          size = $urandom_range(120, 0);
        end
        req.request_size = size;
      end else if (pick < 65) begin
        req.req_type = REQ_COMMIT;
        req.discard = ($urandom_range(99) < 25);
        if (open_offsets.size() != 0 && $urandom_range(99) < 80) begin
          idx = $urandom_range(open_offsets.size() - 1);
          req.sample_offset = open_offsets[idx] + OFF_W'(lo);
          open_offsets.delete(idx);
        end else if (written_slots.size() != 0) begin
          idx = written_slots[$urandom_range(written_slots.size() - 1)];
          req.sample_offset = {SLOT_W'(idx), lo} + OFF_W'(HDR_BYTES);
        end else begin
          req.req_type = REQ_FETCH;
        end
      end else if (pick < 95) begin
        req.req_type = REQ_FETCH;
      end else begin
        req.req_type = REQ_UNUSED;
      end
      issue_request(req);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_size_flags();
    test_capacity();
    test_commit_fetch();
    test_unknown_request();
    drain_results();

    test_random_traffic(376);
    drain_results();

    send_idle_pct = 61;
    take_idle_pct = 16;
    test_random_traffic(376);
    drain_results();

    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random_traffic(376);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_record_ring_buffer_reserve_commit: clean");
    end else begin
      $display("tb_record_ring_buffer_reserve_commit: errors");
    end
    $finish;
  end

endmodule
